// ----- hdl/crrf_pkg.sv -----
// ----------------------------------------------------------------------------
// crrf_pkg
// Shared types and constants of the clipped rounded rectangle fill engine.
// ----------------------------------------------------------------------------
package crrf_pkg;

  localparam int MAX_COLS_DEF = 320;
  localparam int MAX_ROWS_DEF = 240;

  localparam logic [8:0] PANEL_W_RST = 9'd320;
  localparam logic [7:0] PANEL_H_RST = 8'd240;

  typedef enum logic [2:0] {
    CMD_CLEAR    = 3'd0,
    CMD_SET      = 3'd1,
    CMD_READ     = 3'd2,
    CMD_FILL     = 3'd3,
    CMD_OUTLINE  = 3'd4,
    CMD_RFILL    = 3'd5,
    CMD_ROUTLINE = 3'd6,
    CMD_UNUSED   = 3'd7
  } cmd_t;

  typedef enum logic [0:0] {
    CFG_PANEL_W = 1'b0,
    CFG_PANEL_H = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    K_NOP   = 2'd0,
    K_CLEAR = 2'd1,
    K_DRAW  = 2'd2,
    K_READ  = 2'd3
  } kind_t;

  // One classified command as it travels from the front to the back.
  typedef struct packed {
    kind_t       kind;
    logic [15:0] colour;
    logic        ring;
    logic        rd_ok;
    logic        empty;
    logic [11:0] x;
    logic [11:0] w;
    logic [11:0] y;
    logic [11:0] h;
    logic [9:0]  rl;
    logic [19:0] r2;
    logic [19:0] ri2;
    logic [8:0]  x0;
    logic [8:0]  x1;
    logic [7:0]  y0;
    logic [7:0]  y1;
    logic [8:0]  pw;
  } desc_t;

  function automatic logic [15:0] bswap16(input logic [15:0] v);
    bswap16 = {v[7:0], v[15:8]};
  endfunction

endpackage

// ----- hdl/crrf_ram.sv -----
// ----------------------------------------------------------------------------
// crrf_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module crrf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 76800,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/crrf_fifo.sv -----
// ----------------------------------------------------------------------------
// crrf_fifo
// Small register queue used between the front and back and for results.
// ----------------------------------------------------------------------------
module crrf_fifo #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= wdata;
    end
  end

endmodule

// ----- hdl/crrf_front.sv -----
// ----------------------------------------------------------------------------
// crrf_front
// Accepts commands, clips them to the panel and limits the corner radius.
// ----------------------------------------------------------------------------
module crrf_front import crrf_pkg::*; #(
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [2:0]  in_cmd,
  input  logic [11:0] in_pos_x,
  input  logic [11:0] in_pos_y,
  input  logic [11:0] in_size_w,
  input  logic [11:0] in_size_h,
  input  logic [10:0] in_radius,
  input  logic [15:0] in_colour,
  input  logic [8:0]  panel_width,
  input  logic [7:0]  panel_height,
  output logic        desc_push,
  output desc_t       desc,
  input  logic        desc_full
);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_CALC = 4'b0010,
    F_MUL  = 4'b0100,
    F_PUSH = 4'b1000
  } fst_t;

  fst_t        st_r, st_nxt;
  logic [2:0]  cmd_r;
  logic [11:0] x_r, y_r, w_r, h_r;
  logic [10:0] r_r;
  logic [15:0] colour_r;
  desc_t       desc_r;

  logic [8:0]         pw;
  logic [7:0]         ph;
  logic signed [13:0] xs, ys, ws, hs, rs, pw14, ph14;
  logic signed [13:0] xe, ye, x0s, y0s, x1s, y1s, minwh, lim, rl;
  logic               is_round, is_set, c_empty, c_rd_ok;
  logic [9:0]         rlm;
  kind_t              kind;

  assign in_full   = (st_r != F_IDLE);
  assign desc_push = (st_r == F_PUSH);
  assign desc      = desc_r;

  // Panel registers larger than the store act as the store size.
  assign pw = ({23'b0, panel_width} > MAX_COLS) ? 9'(MAX_COLS) : panel_width;
  assign ph = ({24'b0, panel_height} > MAX_ROWS) ? 8'(MAX_ROWS) : panel_height;

  always_comb begin
    is_set   = (cmd_r == CMD_SET);
    is_round = (cmd_r == CMD_RFILL) || (cmd_r == CMD_ROUTLINE);
    pw14  = $signed({5'b0, pw});
    ph14  = $signed({6'b0, ph});
    xs    = $signed({{2{x_r[11]}}, x_r});
    ys    = $signed({{2{y_r[11]}}, y_r});
    ws    = is_set ? 14'sd1 : $signed({{2{w_r[11]}}, w_r});
    hs    = is_set ? 14'sd1 : $signed({{2{h_r[11]}}, h_r});
    rs    = $signed({{3{r_r[10]}}, r_r});
    xe    = xs + ws;
    ye    = ys + hs;
    x0s   = (xs < 14'sd0) ? 14'sd0 : xs;
    y0s   = (ys < 14'sd0) ? 14'sd0 : ys;
    x1s   = (xe > pw14) ? pw14 : xe;
    y1s   = (ye > ph14) ? ph14 : ye;
    c_empty = (ws <= 14'sd0) || (hs <= 14'sd0) || (x0s >= x1s) || (y0s >= y1s);
    minwh = (ws < hs) ? ws : hs;
    lim   = minwh >>> 1;
    rl    = (rs > lim) ? lim : rs;
    if (!is_round || rl < 14'sd0) begin
      rl = 14'sd0;
    end
    c_rd_ok = (xs >= 14'sd0) && (xs < pw14) && (ys >= 14'sd0) && (ys < ph14);
    case (cmd_r)
      CMD_CLEAR:                          kind = K_CLEAR;
      CMD_READ:                           kind = K_READ;
      CMD_SET, CMD_FILL, CMD_OUTLINE,
      CMD_RFILL, CMD_ROUTLINE:            kind = K_DRAW;
      default:                            kind = K_NOP;
    endcase
    rlm = desc_r.rl - 10'd1;
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      F_IDLE:  if (in_push) st_nxt = F_CALC;
      F_CALC:  st_nxt = F_MUL;
      F_MUL:   st_nxt = F_PUSH;
      F_PUSH:  if (!desc_full) st_nxt = F_IDLE;
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == F_IDLE && in_push) begin
      cmd_r    <= in_cmd;
      x_r      <= in_pos_x;
      y_r      <= in_pos_y;
      w_r      <= in_size_w;
      h_r      <= in_size_h;
      r_r      <= in_radius;
      colour_r <= in_colour;
    end
    if (st_r == F_CALC) begin
      desc_r.kind   <= kind;
      desc_r.colour <= colour_r;
      desc_r.ring   <= (cmd_r == CMD_OUTLINE) || (cmd_r == CMD_ROUTLINE);
      desc_r.rd_ok  <= c_rd_ok;
      desc_r.empty  <= c_empty;
      desc_r.x      <= x_r;
      desc_r.y      <= y_r;
      desc_r.w      <= ws[11:0];
      desc_r.h      <= hs[11:0];
      desc_r.rl     <= rl[9:0];
      desc_r.pw     <= pw;
      // A read addresses its own pixel; a shape starts at its clipped corner.
      desc_r.x0     <= (kind == K_READ) ? xs[8:0] : x0s[8:0];
      desc_r.y0     <= (kind == K_READ) ? ys[7:0] : y0s[7:0];
      desc_r.x1     <= x1s[8:0];
      desc_r.y1     <= y1s[7:0];
    end
    if (st_r == F_MUL) begin
      desc_r.r2  <= {10'b0, desc_r.rl} * {10'b0, desc_r.rl};
      desc_r.ri2 <= {10'b0, rlm} * {10'b0, rlm};
    end
  end

endmodule

// ----- hdl/crrf_back.sv -----
// ----------------------------------------------------------------------------
// crrf_back
// Walks each drawing command's clipped box one pixel a cycle; also clears and reads.
// ----------------------------------------------------------------------------
module crrf_back import crrf_pkg::*; #(
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  localparam int DEPTH = MAX_COLS * MAX_ROWS,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        desc_empty,
  input  desc_t       desc_head,
  output logic        desc_pop,
  output logic        res_push,
  output logic [15:0] res_data,
  input  logic        res_full
);

  typedef enum logic [7:0] {
    B_IDLE  = 8'b00000001,
    B_SETUP = 8'b00000010,
    B_CLEAR = 8'b00000100,
    B_SCAN  = 8'b00001000,
    B_DRAIN = 8'b00010000,
    B_READ  = 8'b00100000,
    B_RWAIT = 8'b01000000,
    B_DONE  = 8'b10000000
  } bst_t;

  bst_t          st_r, st_nxt;
  desc_t         cur_r;
  logic [AW-1:0] addr_r, row_r;
  logic [8:0]    px_r;
  logic [7:0]    py_r;
  logic [15:0]   res_r;
  logic [17:0]   row_base;

  // Pixel pipeline: a = position, b = corner offsets, c = squared offsets.
  logic          a_v_r, b_v_r, c_v_r;
  logic [8:0]    a_px_r;
  logic [7:0]    a_py_r;
  logic [AW-1:0] a_addr_r, b_addr_r, c_addr_r;
  logic [9:0]    b_ox_r, b_oy_r;
  logic          b_corner_r, b_edge_r, c_corner_r, c_edge_r;
  logic [19:0]   c_ox2_r, c_oy2_r;

  logic signed [13:0] xs, ys, ws, hs, rl14, lx, ly, dx, dy, oxs, oys;
  logic               cxl, cxh, cyl, cyh;
  logic [20:0]        dsum;
  logic               draw;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [15:0]        rdata;
  logic               last_px, last_row;

  assign desc_pop = (st_r == B_IDLE) && !desc_empty;
  assign res_push = (st_r == B_DONE);
  assign res_data = res_r;
  assign row_base = {10'b0, cur_r.y0} * {9'b0, cur_r.pw};
  assign last_px  = (px_r == cur_r.x1 - 9'd1);
  assign last_row = (py_r == cur_r.y1 - 8'd1);

  // Corner geometry of the pixel in stage a.
  always_comb begin
    xs   = $signed({{2{cur_r.x[11]}}, cur_r.x});
    ys   = $signed({{2{cur_r.y[11]}}, cur_r.y});
    ws   = $signed({{2{cur_r.w[11]}}, cur_r.w});
    hs   = $signed({{2{cur_r.h[11]}}, cur_r.h});
    rl14 = $signed({4'b0, cur_r.rl});
    lx   = $signed({5'b0, a_px_r}) - xs;
    ly   = $signed({6'b0, a_py_r}) - ys;
    cxl  = lx < rl14;
    cxh  = lx >= ws - rl14;
    cyl  = ly < rl14;
    cyh  = ly >= hs - rl14;
    dx   = cxl ? lx : ws - 14'sd1 - lx;
    dy   = cyl ? ly : hs - 14'sd1 - ly;
    oxs  = rl14 - dx;
    oys  = rl14 - dy;
  end

  always_comb begin
    dsum = {1'b0, c_ox2_r} + {1'b0, c_oy2_r};
    if (c_corner_r) begin
      draw = (dsum <= {1'b0, cur_r.r2}) && (!cur_r.ring || dsum > {1'b0, cur_r.ri2});
    end else begin
      draw = !cur_r.ring || c_edge_r;
    end
    if (st_r == B_CLEAR) begin
      we    = 1'b1;
      waddr = addr_r;
    end else begin
      we    = c_v_r && draw;
      waddr = c_addr_r;
    end
  end

  crrf_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (bswap16(cur_r.colour)),
    .raddr (addr_r),
    .rdata (rdata)
  );

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      B_IDLE:  if (!desc_empty) st_nxt = B_SETUP;
      B_SETUP: begin
        case (cur_r.kind)
          K_CLEAR: st_nxt = B_CLEAR;
          K_READ:  st_nxt = B_READ;
          K_DRAW:  st_nxt = cur_r.empty ? B_DONE : B_SCAN;
          default: st_nxt = B_DONE;
        endcase
      end
      B_CLEAR: if (addr_r == AW'(DEPTH - 1)) st_nxt = B_DONE;
      B_SCAN:  if (last_px && last_row) st_nxt = B_DRAIN;
      B_DRAIN: if (!a_v_r && !b_v_r && !c_v_r) st_nxt = B_DONE;
      B_READ:  st_nxt = B_RWAIT;
      B_RWAIT: st_nxt = B_DONE;
      B_DONE:  if (!res_full) st_nxt = B_IDLE;
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= B_IDLE;
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      a_v_r <= (st_r == B_SCAN);
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (desc_pop) begin
      cur_r <= desc_head;
    end
    case (st_r)
      B_SETUP: begin
        res_r  <= 16'd0;
        px_r   <= cur_r.x0;
        py_r   <= cur_r.y0;
        row_r  <= AW'(row_base);
        addr_r <= (cur_r.kind == K_CLEAR) ? '0 : AW'(row_base + {9'b0, cur_r.x0});
      end
      B_CLEAR: addr_r <= addr_r + 1'b1;
      B_SCAN: begin
        if (last_px) begin
          px_r   <= cur_r.x0;
          py_r   <= py_r + 8'd1;
          row_r  <= row_r + AW'(cur_r.pw);
          addr_r <= row_r + AW'(cur_r.pw) + AW'(cur_r.x0);
        end else begin
          px_r   <= px_r + 9'd1;
          addr_r <= addr_r + 1'b1;
        end
      end
      B_RWAIT: res_r <= cur_r.rd_ok ? bswap16(rdata) : 16'd0;
      default: ;
    endcase
    a_px_r     <= px_r;
    a_py_r     <= py_r;
    a_addr_r   <= addr_r;
    b_addr_r   <= a_addr_r;
    b_ox_r     <= oxs[9:0];
    b_oy_r     <= oys[9:0];
    b_corner_r <= (cxl || cxh) && (cyl || cyh);
    b_edge_r   <= (lx == 14'sd0) || (lx == ws - 14'sd1) ||
                  (ly == 14'sd0) || (ly == hs - 14'sd1);
    c_addr_r   <= b_addr_r;
    c_corner_r <= b_corner_r;
    c_edge_r   <= b_edge_r;
    c_ox2_r    <= {10'b0, b_ox_r} * {10'b0, b_ox_r};
    c_oy2_r    <= {10'b0, b_oy_r} * {10'b0, b_oy_r};
  end

endmodule

// ----- hdl/clipped_rounded_rect_fill_engine.sv -----
// ----------------------------------------------------------------------------
// clipped_rounded_rect_fill_engine
// RGB565 drawing engine with panel clipping and rounded corners.
// ----------------------------------------------------------------------------
// A command is taken by the front at its accepting edge and classified in the
// states F_CALC, F_MUL and F_PUSH, during which the input shows full (longer
// while the command queue is full). The back then walks the clipped bounding
// box of the shape at one pixel per cycle through a three-stage corner test; a
// clear writes the whole store, MAX_COLS*MAX_ROWS pixels, through the single
// store write port. One result item comes back per command, in order; it
// carries the pixel colour for a read inside the panel and zero otherwise. The
// store is not cleared at reset: read only pixels that were written since.
module clipped_rounded_rect_fill_engine import crrf_pkg::*; #(
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [2:0]  in_cmd,
  input  logic [11:0] in_pos_x,
  input  logic [11:0] in_pos_y,
  input  logic [11:0] in_size_w,
  input  logic [11:0] in_size_h,
  input  logic [10:0] in_radius,
  input  logic [15:0] in_colour,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [15:0] out_read_colour,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  logic [8:0] panel_w_r;
  logic [7:0] panel_h_r;
  logic       desc_push, desc_full, desc_empty, desc_pop;
  desc_t      desc_in, desc_head;
  logic       res_push, res_full;
  logic [15:0] res_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      panel_w_r <= PANEL_W_RST;
      panel_h_r <= PANEL_H_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PANEL_W: panel_w_r <= cfg_data;
        CFG_PANEL_H: panel_h_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  crrf_front #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_cmd       (in_cmd),
    .in_pos_x     (in_pos_x),
    .in_pos_y     (in_pos_y),
    .in_size_w    (in_size_w),
    .in_size_h    (in_size_h),
    .in_radius    (in_radius),
    .in_colour    (in_colour),
    .panel_width  (panel_w_r),
    .panel_height (panel_h_r),
    .desc_push    (desc_push),
    .desc         (desc_in),
    .desc_full    (desc_full)
  );

  crrf_fifo #(.WIDTH($bits(desc_t)), .DEPTH(2)) u_desc_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (desc_push),
    .wdata (desc_in),
    .pop   (desc_pop),
    .rdata (desc_head),
    .full  (desc_full),
    .empty (desc_empty)
  );

  crrf_back #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .desc_empty (desc_empty),
    .desc_head  (desc_head),
    .desc_pop   (desc_pop),
    .res_push   (res_push),
    .res_data   (res_data),
    .res_full   (res_full)
  );

  crrf_fifo #(.WIDTH(16), .DEPTH(2)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_data),
    .pop   (out_pop),
    .rdata (out_read_colour),
    .full  (res_full),
    .empty (out_empty)
  );

endmodule

// ----- hdl/crrf_checker.sv -----
// ----------------------------------------------------------------------------
// crrf_checker
// Port-level checks of the fill engine, bound to the top level.
// ----------------------------------------------------------------------------
module crrf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_push,
  input logic        in_full,
  input logic        out_empty,
  input logic        out_pop,
  input logic [15:0] out_read_colour
);

  // Reset leaves no result waiting and the input open.
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");
  a_rst_open: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input not open after reset");

  // The front works on one item at a time, so an accepted item closes the input.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_push && !in_full |=> in_full)
    else $error("input stayed open after an accepted item");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_read_colour))
    else $error("waiting result changed or vanished");

endmodule

bind clipped_rounded_rect_fill_engine crrf_checker u_chk (.*);
